// File: hdl/cle_pkg.sv
// shared types, codes and constants of the cursor line editor buffer
package cle_pkg;

   // default text capacity in characters
   localparam int CAPACITY_DEF = 64;

   // depth of the command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);

   // request codes as they arrive on req_type
   localparam logic [2:0] REQ_LEFT   = 3'd0;
   localparam logic [2:0] REQ_RIGHT  = 3'd1;
   localparam logic [2:0] REQ_DELETE = 3'd2;
   localparam logic [2:0] REQ_INSERT = 3'd3;
   localparam logic [2:0] REQ_DUMP   = 3'd4;

   // result status codes
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_BOUNDARY = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_DUMP     = 2'd3;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_LEFT,
      OP_RIGHT,
      OP_DELETE,
      OP_INSERT,
      OP_DUMP,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] char_in;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] char_out;
      logic       last_item;
      logic       text_empty;
   } rsp_item_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] ch;
   } cmd_type;

   // head of the command queue as the back sees it
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

endpackage

// File: hdl/cle_ram.sv
// generic single write port, single read port ram with registered read
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cle_front.sv
// request intake: classifies requests and holds them in a short command queue
module cle_front
   import cle_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req,
   input  logic         pop,
   output q_head_type   head
);

   cmd_type           q_ff [QDEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              push;
   cmd_type           cls;

   // decode the request code, unknown codes become a no-op
   always_comb begin
      cls.ch = req.char_in;
      unique case (req.req_type)
         REQ_LEFT:   cls.op = OP_LEFT;
         REQ_RIGHT:  cls.op = OP_RIGHT;
         REQ_DELETE: cls.op = OP_DELETE;
         REQ_INSERT: cls.op = OP_INSERT;
         REQ_DUMP:   cls.op = OP_DUMP;
         default:    cls.op = OP_NOP;
      endcase
   end

   assign busy = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign push = start && !busy;

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= cls;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.cmd   = q_ff[rptr_ff];

endmodule

// File: hdl/cle_back.sv
// command execution: the two text stacks, cursor moves, edits and dump streaming
module cle_back
   import cle_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  q_head_type   head,
   output logic         pop,
   output logic         rsp_valid,
   output rsp_item_type rsp
);

   localparam int LEN_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_MOVE_L = 2'd1;
   localparam logic [1:0] S_MOVE_R = 2'd2;
   localparam logic [1:0] S_DUMP   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [LEN_W-1:0] llen_ff, llen_in;
   logic [LEN_W-1:0] rlen_ff, rlen_in;
   logic [LEN_W-1:0] k_ff, k_in;
   logic [LEN_W-1:0] total;
   logic [LEN_W-1:0] total_m1;

   logic             evld_ff, evld_in;
   rsp_item_type     erslt_ff, erslt_in;
   logic             dvld_ff, dvld_in;
   logic             dsel_ff, dsel_in;
   logic             dlast_ff, dlast_in;

   logic              lwe, lre, rwe, rre;
   logic [ADDR_W-1:0] lwa, lra, rwa, rra;
   logic [7:0]        lwd, rwd, lrd, rrd;

   assign total    = llen_ff + rlen_ff;
   assign total_m1 = total - 1'b1;

   always_comb begin
      state_in = state_ff;
      llen_in  = llen_ff;
      rlen_in  = rlen_ff;
      k_in     = k_ff;
      pop      = 1'b0;
      lwe = 1'b0; lwa = '0; lwd = '0; lre = 1'b0; lra = '0;
      rwe = 1'b0; rwa = '0; rwd = '0; rre = 1'b0; rra = '0;
      evld_in  = 1'b0;
      erslt_in = '{status: ST_BOUNDARY, char_out: 8'd0, last_item: 1'b1,
                   text_empty: 1'b0};
      dvld_in  = 1'b0;
      dsel_in  = dsel_ff;
      dlast_in = dlast_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               unique case (head.cmd.op)
                  OP_LEFT: begin
                     if (llen_ff != '0 && rlen_ff < LEN_W'(CAPACITY)) begin
                        lre      = 1'b1;
                        lra      = ADDR_W'(llen_ff - 1'b1);
                        state_in = S_MOVE_L;
                     end else begin
                        evld_in = 1'b1;
                     end
                  end
                  OP_RIGHT: begin
                     if (rlen_ff != '0 && llen_ff < LEN_W'(CAPACITY)) begin
                        rre      = 1'b1;
                        rra      = ADDR_W'(rlen_ff - 1'b1);
                        state_in = S_MOVE_R;
                     end else begin
                        evld_in = 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     evld_in = 1'b1;
                     if (llen_ff != '0) begin
                        llen_in         = llen_ff - 1'b1;
                        erslt_in.status = ST_DONE;
                     end
                  end
                  OP_INSERT: begin
                     evld_in = 1'b1;
                     if (total >= LEN_W'(CAPACITY)) begin
                        erslt_in.status = ST_FULL;
                     end else begin
                        lwe             = 1'b1;
                        lwa             = ADDR_W'(llen_ff);
                        lwd             = head.cmd.ch;
                        llen_in         = llen_ff + 1'b1;
                        erslt_in.status = ST_DONE;
                     end
                  end
                  OP_DUMP: begin
                     if (total == '0) begin
                        evld_in             = 1'b1;
                        erslt_in.status     = ST_DUMP;
                        erslt_in.text_empty = 1'b1;
                     end else begin
                        k_in     = '0;
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                     evld_in = 1'b1;
                  end
               endcase
            end
         end
         S_MOVE_L: begin
            rwe             = 1'b1;
            rwa             = ADDR_W'(rlen_ff);
            rwd             = lrd;
            llen_in         = llen_ff - 1'b1;
            rlen_in         = rlen_ff + 1'b1;
            evld_in         = 1'b1;
            erslt_in.status = ST_DONE;
            state_in        = S_IDLE;
         end
         S_MOVE_R: begin
            lwe             = 1'b1;
            lwa             = ADDR_W'(llen_ff);
            lwd             = rrd;
            rlen_in         = rlen_ff - 1'b1;
            llen_in         = llen_ff + 1'b1;
            evld_in         = 1'b1;
            erslt_in.status = ST_DONE;
            state_in        = S_IDLE;
         end
         S_DUMP: begin
            dvld_in  = 1'b1;
            dlast_in = (k_ff == total_m1);
            if (k_ff < llen_ff) begin
               lre     = 1'b1;
               lra     = ADDR_W'(k_ff);
               dsel_in = 1'b0;
            end else begin
               rre     = 1'b1;
               rra     = ADDR_W'(total_m1 - k_ff);
               dsel_in = 1'b1;
            end
            k_in = k_ff + 1'b1;
            if (k_ff == total_m1) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         llen_ff  <= '0;
         rlen_ff  <= '0;
         k_ff     <= '0;
         evld_ff  <= 1'b0;
         dvld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         llen_ff  <= llen_in;
         rlen_ff  <= rlen_in;
         k_ff     <= k_in;
         evld_ff  <= evld_in;
         dvld_ff  <= dvld_in;
      end
   end

   always_ff @(posedge clock) begin
      erslt_ff <= erslt_in;
      dsel_ff  <= dsel_in;
      dlast_ff <= dlast_in;
   end

   cle_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_left (
      .clock   (clock),
      .wr_en   (lwe),
      .wr_addr (lwa),
      .wr_data (lwd),
      .rd_en   (lre),
      .rd_addr (lra),
      .rd_data (lrd)
   );

   cle_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_right (
      .clock   (clock),
      .wr_en   (rwe),
      .wr_addr (rwa),
      .wr_data (rwd),
      .rd_en   (rre),
      .rd_addr (rra),
      .rd_data (rrd)
   );

   // dump data and edit results never fall in the same cycle
   always_comb begin
      rsp_valid = evld_ff || dvld_ff;
      if (dvld_ff) begin
         rsp.status     = ST_DUMP;
         rsp.char_out   = dsel_ff ? rrd : lrd;
         rsp.last_item  = dlast_ff;
         rsp.text_empty = 1'b0;
      end else begin
         rsp = erslt_ff;
      end
   end

endmodule

// File: hdl/cursor_line_editor_buffer_core.sv
// top level of the cursor line editor buffer
//
// usage
// - request channel: a request (req.req_type, req.char_in) is taken at a rising
//   edge where start is high and busy is low; busy is high while the
//   two-entry command queue is full
// - result channel: each result sits on rsp for exactly one cycle with
//   rsp_valid high; the receiver cannot stall, so it must take every strobe
// - path: a taken request is registered in the command queue; the executor
//   pops it when idle, and delete, insert, no-op and boundary results are
//   registered from that decision, cursor move results after a move state (stack
//   ram read before the write to the other stack); delete, insert and no-op
//   finish in the idle state, while a dump pops the queue, then reads the ram
//   once per character
// - dump results stream one character per cycle, last_item on the final one;
//   empty text gives a single result with text_empty set
// - reset clears the stack lengths, queue and state; the stack rams are
//   not cleared, and no entry above a stack length is ever read
module cursor_line_editor_buffer_core
   import cle_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req,
   output logic         rsp_valid,
   output rsp_item_type rsp
);

   // queue head from front to back and its pop
   q_head_type head;
   logic       pop;

   // classify and queue requests
   cle_front u_front (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .req   (req),
      .pop   (pop),
      .head  (head)
   );

   // execute commands against the two stacks
   cle_back #(.CAPACITY(CAPACITY)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

// File: hdl/cle_checker.sv
// port level checks of the cursor line editor buffer, bound to the top level
module cle_checker
   import cle_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_item_type req,
   input logic         rsp_valid,
   input rsp_item_type rsp
);

   // no result right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // edit results are single and carry no character
   a_edit_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status != ST_DUMP) |-> (rsp.last_item && rsp.char_out == 8'd0
         && !rsp.text_empty))
      else $error("malformed edit result");

   // empty dump is a lone final dump result with zero data
   a_empty_dump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.text_empty) |-> (rsp.status == ST_DUMP && rsp.last_item
         && rsp.char_out == 8'd0))
      else $error("malformed empty dump result");

   // a dump result that is not last is followed by another dump result
   a_dump_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status == ST_DUMP && !rsp.last_item) |=>
         (rsp_valid && rsp.status == ST_DUMP && !rsp.text_empty))
      else $error("dump stream broken");

endmodule

bind cursor_line_editor_buffer_core cle_checker u_cle_checker (.*);
